@@ hdl/tspp_pkg.sv @@
`default_nettype none

package tspp_pkg;

  localparam int PID_W      = 13;
  localparam int TBL_DEPTH  = 8192;
  localparam int TBL_W      = 6;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [7:0] SYNC_BYTE = 8'h47;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_SYNC      = 3'd1,
    ST_TRANSPORT_ERR = 3'd2,
    ST_SCRAMBLED     = 3'd3,
    ST_CC_ERR        = 3'd4,
    ST_OVERRUN       = 3'd5
  } tspp_status_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_AF_LEN,
    PH_AF_FLAGS,
    PH_AF_BODY,
    PH_PAYLOAD
  } tspp_phase_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         payload_byte;
    logic [PID_W-1:0]   pid;
    logic               unit_start;
    logic               random_access;
    tspp_status_t       status;
    logic               has_pcr;
    logic [32:0]        pcr_90k;
    logic [8:0]         pcr_ext;
    logic               last;
  } tspp_result_t;

  typedef struct packed {
    logic          a_valid;
    tspp_result_t  a;
    logic          b_valid;
    tspp_result_t  b;
  } tspp_push_t;

  typedef struct packed {
    logic              rd_en;
    logic [PID_W-1:0]  rd_addr;
    logic              wr_en;
    logic [PID_W-1:0]  wr_addr;
    logic [TBL_W-1:0]  wr_data;
  } tspp_tbl_req_t;

endpackage

`default_nettype wire

@@ hdl/ts_packet_parser_cc_check.sv @@
`default_nettype none

// Transport stream packet parser with per-PID continuity check. Bytes enter
// one per beat on the in_ channel and are framed into packets of PACKET_BYTES
// bytes by a free-running counter that never resynchronizes. Payload bytes of
// a clean packet that carries payload, once a unit has started on its PID,
// leave as kind-0 beats; the last byte of every packet yields a kind-1 report
// with status, PID and raw PCR (33-bit base, 9-bit extension). The block takes
// one byte per cycle: the parse state sits in registers updated every beat,
// and the PID table (8192 x 6 bits, one synchronous RAM) is read once per
// packet, issued with the third header byte, and written at the last byte of
// a clean packet, so the read-modify-write never overlaps. A four-beat output
// queue takes up to two beats per byte and holds the input off only when fewer
// than two slots are free. After reset the table is cleared one entry per
// cycle; in_tready stays low until the clear is done.
module ts_packet_parser_cc_check
  import tspp_pkg::*;
#(
  parameter int PACKET_BYTES = 188
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [7:0] payload_byte, [20:8] pid, [21] unit_start,
                                       // [22] random_access, [25:23] status, [26] has_pcr,
                                       // [59:27] pcr_90k, [68:60] pcr_ext, [71:69] zero
  output logic             out_tuser,  // [0] kind
  output logic             out_tlast
);

  logic                clearing_r;
  logic [PID_W-1:0]    clr_addr_r;
  logic                room;
  logic                accept;
  tspp_tbl_req_t       tbl_req;
  tspp_push_t          push;
  tspp_result_t        out_res;
  logic [TBL_W-1:0]    tbl_rd_data;
  logic                ram_wr_en;
  logic [PID_W-1:0]    ram_wr_addr;
  logic [TBL_W-1:0]    ram_wr_data;

  assign in_tready = !clearing_r && room;
  assign accept    = in_tvalid && in_tready;

  // clearing pass owns the write port until it is done
  assign ram_wr_en   = clearing_r || tbl_req.wr_en;
  assign ram_wr_addr = clearing_r ? clr_addr_r : tbl_req.wr_addr;
  assign ram_wr_data = clearing_r ? '0 : tbl_req.wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + PID_W'(1);
      if (clr_addr_r == PID_W'(TBL_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  tspp_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_pid_tbl (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (tbl_req.rd_en),
    .rd_addr (tbl_req.rd_addr),
    .rd_data (tbl_rd_data)
  );

  tspp_parser #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .tbl_rd_data (tbl_rd_data),
    .tbl_req     (tbl_req),
    .push        (push)
  );

  tspp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {3'b000, out_res.pcr_ext, out_res.pcr_90k, out_res.has_pcr,
                      out_res.status, out_res.random_access, out_res.unit_start,
                      out_res.pid, out_res.payload_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  // no byte may enter while the table is still being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !accept)
    else $error("byte accepted during table clear");

  // a table read never meets a write to the same entry
  a_no_tbl_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl_req.rd_en && ram_wr_en && (tbl_req.rd_addr == ram_wr_addr)))
    else $error("PID table read and write collide");

  // a report always closes the results of its byte
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("report beat without tlast");

  // payload beats carry no status and no PCR
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_res.status == ST_OK) && !out_res.has_pcr && (out_res.pcr_90k == 33'd0))
    else $error("payload beat with status or PCR");

endmodule

`default_nettype wire

@@ hdl/tspp_ram.sv @@
`default_nettype none

module tspp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/tspp_parser.sv @@
`default_nettype none

module tspp_parser
  import tspp_pkg::*;
#(
  parameter int PACKET_BYTES = 188
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic [TBL_W-1:0] tbl_rd_data,
  output tspp_tbl_req_t         tbl_req,
  output tspp_push_t            push
);

  localparam int IDX_W = $clog2(PACKET_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

  logic [IDX_W-1:0] idx_r;
  tspp_phase_t      phase_r, phase_nxt;
  logic [23:0]      hdr_r, hdr_nxt;
  logic [7:0]       alen_r, alen_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [47:0]      pcr_sh_r, pcr_sh_nxt;
  logic [2:0]       pcnt_r, pcnt_nxt;
  tspp_status_t     status_r, status_nxt;
  logic             pcr_flag_r, pcr_flag_nxt;
  logic             rai_r, rai_nxt;
  logic             overrun_r, overrun_nxt;
  logic             cc_err_r, cc_err_nxt;
  logic             seen_r, seen_nxt;

  logic             first;
  logic             pkt_end;
  logic             fwd;
  tspp_status_t     rpt_status;
  logic             rpt_pcr;

  function automatic tspp_status_t final_status(tspp_status_t st, logic ovr, logic cce);
    tspp_status_t res;
    if (st != ST_OK) res = st;
    else if (ovr)    res = ST_OVERRUN;
    else if (cce)    res = ST_CC_ERR;
    else             res = ST_OK;
    return res;
  endfunction

  assign first   = (idx_r == '0);
  assign pkt_end = (idx_r == LAST_IDX);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (first) begin
      phase_nxt = PH_HEADER;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          if (idx_r == IDX_W'(3)) begin
            phase_nxt = data_byte[5] ? PH_AF_LEN : PH_PAYLOAD;
          end
        end
        PH_AF_LEN: begin
          phase_nxt = (data_byte == 8'd0) ? PH_PAYLOAD : PH_AF_FLAGS;
        end
        PH_AF_FLAGS: begin
          phase_nxt = ((alen_r - 8'd1) != 8'd0) ? PH_AF_BODY : PH_PAYLOAD;
        end
        PH_AF_BODY: begin
          phase_nxt = ((rem_r - 8'd1) == 8'd0) ? PH_PAYLOAD : PH_AF_BODY;
        end
        PH_PAYLOAD: begin
          phase_nxt = PH_PAYLOAD;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  // field updates
  always_comb begin
    hdr_nxt      = hdr_r;
    alen_nxt     = alen_r;
    rem_nxt      = rem_r;
    pcr_sh_nxt   = pcr_sh_r;
    pcnt_nxt     = pcnt_r;
    status_nxt   = status_r;
    pcr_flag_nxt = pcr_flag_r;
    rai_nxt      = rai_r;
    overrun_nxt  = overrun_r;
    cc_err_nxt   = cc_err_r;
    seen_nxt     = seen_r;
    fwd          = 1'b0;
    if (first) begin
      status_nxt   = (data_byte != SYNC_BYTE) ? ST_BAD_SYNC : ST_OK;
      hdr_nxt      = '0;
      alen_nxt     = '0;
      rem_nxt      = '0;
      pcr_sh_nxt   = '0;
      pcnt_nxt     = '0;
      pcr_flag_nxt = 1'b0;
      rai_nxt      = 1'b0;
      overrun_nxt  = 1'b0;
      cc_err_nxt   = 1'b0;
      seen_nxt     = 1'b0;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_nxt = {hdr_r[15:0], data_byte};
          if (idx_r == IDX_W'(3)) begin
            if (status_r == ST_OK) begin
              if (hdr_nxt[23])               status_nxt = ST_TRANSPORT_ERR;
              else if (hdr_nxt[7:6] != 2'b0) status_nxt = ST_SCRAMBLED;
            end
            cc_err_nxt = tbl_rd_data[5] && ((tbl_rd_data[3:0] + 4'd1) != hdr_nxt[3:0]);
            seen_nxt   = tbl_rd_data[4];
          end
        end
        PH_AF_LEN: begin
          alen_nxt = data_byte;
          if ((data_byte != 8'd0) && ((32'(data_byte) + 32'd5) > 32'(PACKET_BYTES))) begin
            overrun_nxt = 1'b1;
          end
        end
        PH_AF_FLAGS: begin
          rai_nxt      = data_byte[6];
          pcr_flag_nxt = data_byte[4];
          if (data_byte[4] && (alen_r < 8'd7)) begin
            overrun_nxt = 1'b1;
          end
          rem_nxt = alen_r - 8'd1;
        end
        PH_AF_BODY: begin
          if (pcr_flag_r && (pcnt_r < 3'd6)) begin
            pcr_sh_nxt = {pcr_sh_r[39:0], data_byte};
            pcnt_nxt   = pcnt_r + 3'd1;
          end
          rem_nxt = rem_r - 8'd1;
        end
        PH_PAYLOAD: begin
          fwd = (final_status(status_r, overrun_r, cc_err_r) == ST_OK) && hdr_r[4] &&
                (hdr_r[22] || seen_r);
        end
        default: begin
          fwd = 1'b0;
        end
      endcase
    end
  end

  assign rpt_status = final_status(status_nxt, overrun_nxt, cc_err_nxt);
  assign rpt_pcr    = pcr_flag_nxt && (alen_nxt >= 8'd7) && (pcnt_nxt >= 3'd6);

  // results: payload beat first, then the report
  always_comb begin
    push.a_valid         = accept && fwd;
    push.a.kind          = 1'b0;
    push.a.payload_byte  = data_byte;
    push.a.pid           = hdr_nxt[20:8];
    push.a.unit_start    = hdr_nxt[22];
    push.a.random_access = rai_nxt;
    push.a.status        = ST_OK;
    push.a.has_pcr       = 1'b0;
    push.a.pcr_90k       = '0;
    push.a.pcr_ext       = '0;
    push.a.last          = !pkt_end;

    push.b_valid         = accept && pkt_end;
    push.b.kind          = 1'b1;
    push.b.payload_byte  = '0;
    push.b.pid           = hdr_nxt[20:8];
    push.b.unit_start    = hdr_nxt[22];
    push.b.random_access = rai_nxt;
    push.b.status        = rpt_status;
    push.b.has_pcr       = rpt_pcr;
    push.b.pcr_90k       = rpt_pcr ? pcr_sh_nxt[47:15] : 33'd0;
    push.b.pcr_ext       = rpt_pcr ? pcr_sh_nxt[8:0] : 9'd0;
    push.b.last          = 1'b1;
  end

  // fetch the entry once the PID is complete; update it on a clean last byte
  always_comb begin
    tbl_req.rd_en   = accept && !first && (phase_r == PH_HEADER) && (idx_r == IDX_W'(2));
    tbl_req.rd_addr = {hdr_r[4:0], data_byte};
    tbl_req.wr_en   = accept && pkt_end && (rpt_status == ST_OK);
    tbl_req.wr_addr = hdr_nxt[20:8];
    tbl_req.wr_data = {1'b1, seen_nxt | hdr_nxt[22], hdr_nxt[3:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      phase_r    <= PH_HEADER;
      hdr_r      <= '0;
      alen_r     <= '0;
      rem_r      <= '0;
      pcr_sh_r   <= '0;
      pcnt_r     <= '0;
      status_r   <= ST_OK;
      pcr_flag_r <= 1'b0;
      rai_r      <= 1'b0;
      overrun_r  <= 1'b0;
      cc_err_r   <= 1'b0;
      seen_r     <= 1'b0;
    end else if (accept) begin
      idx_r      <= pkt_end ? '0 : idx_r + IDX_W'(1);
      phase_r    <= phase_nxt;
      hdr_r      <= hdr_nxt;
      alen_r     <= alen_nxt;
      rem_r      <= rem_nxt;
      pcr_sh_r   <= pcr_sh_nxt;
      pcnt_r     <= pcnt_nxt;
      status_r   <= status_nxt;
      pcr_flag_r <= pcr_flag_nxt;
      rai_r      <= rai_nxt;
      overrun_r  <= overrun_nxt;
      cc_err_r   <= cc_err_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tspp_out_queue.sv @@
`default_nettype none

module tspp_out_queue
  import tspp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tspp_push_t push,
  output logic            room,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tspp_result_t    out_res
);

  tspp_result_t      q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QCNT_W-1:0] npush;
  logic              pop;

  assign room      = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign npush     = QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid);
  assign cnt_nxt   = cnt_r + npush - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      q_r[wp_r] <= push.a;
      if (push.b_valid) begin
        q_r[wp_r + QPTR_W'(1)] <= push.b;
      end
    end else if (push.b_valid) begin
      q_r[wp_r] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + npush[QPTR_W-1:0];
      rp_r  <= rp_r + QPTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
